// ===== design/sacl_pkg.sv =====
// Shared types and constants of the set-associative cache tag store.
// Used by the controller, the datapath and the top level.
package sacl_pkg;

  localparam int PHYS_ADDR_W = 48;
  localparam int CNT_W       = 32;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BLOCK_OFFSET = 2'd0;
  localparam logic [1:0] CFG_SET_BITS     = 2'd1;
  localparam logic [1:0] CFG_WAYS         = 2'd2;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [PHYS_ADDR_W-1:0] phys_addr;
  } req_t;

  typedef struct packed {
    logic             was_hit;
    logic [2:0]       way_used;
    logic [9:0]       set_used;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] read_misses;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] write_misses;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic finish;
    logic sweep_wr;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic flush_req;
    logic sweep_last;
    logic out_hold;
  } sts_t;

endpackage

// ===== design/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sacl_ctrl.sv =====
// Sequencing controller of the cache tag store: clearing sweep, accept, lookup.
// Depends on sacl_pkg for command and status types.
module sacl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  sacl_pkg::sts_t sts,
  output sacl_pkg::cmd_t cmd
);
  import sacl_pkg::*;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!sts.out_hold) begin
          cmd.finish = 1'b1;
          state_next = sts.flush_req ? ST_SWEEP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  // State register; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_CMP) else $error("accept did not start lookup");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.out_hold) else $error("result written over a held one");
  a_flush_sweep: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && sts.flush_req) |=> state == ST_SWEEP) else $error("flush skipped sweep");
  a_sweep_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_wr |-> in_stall) else $error("input taken during sweep");
`endif

endmodule

// ===== design/sacl_dp.sv =====
// Datapath of the cache tag store: config, address split, set RAM, hit/LRU logic,
// counters and result register. Depends on sacl_pkg and sacl_ram.
module sacl_dp #(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  sacl_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output sacl_pkg::rsp_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [4:0]      cfg_data,
  input  sacl_pkg::cmd_t  cmd,
  output sacl_pkg::sts_t  sts
);
  import sacl_pkg::*;

  localparam int AW      = ADDR_BITS < PHYS_ADDR_W ? ADDR_BITS : PHYS_ADDR_W;
  localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W   = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W   = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int ENTRY_W = 1 + AW + WAY_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;

  // Configuration registers
  logic [4:0] cfg_bo;
  logic [3:0] cfg_sb;
  logic [3:0] cfg_ways;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_bo   <= 5'd6;
      cfg_sb   <= 4'd7;
      cfg_ways <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_OFFSET: cfg_bo   <= cfg_data;
        CFG_SET_BITS:     cfg_sb   <= cfg_data[3:0];
        CFG_WAYS:         cfg_ways <= cfg_data[3:0];
        default:          ;
      endcase
    end
  end

  // Effective set bits and ways
  logic [3:0]        sbits;
  logic [4:0]        ways5;
  logic [WCNT_W-1:0] ways_eff;

  always_comb begin
    sbits = cfg_sb;
    if ({1'b0, cfg_sb} > 5'(SET_LOG)) begin
      sbits = 4'(SET_LOG);
    end
    ways5 = {1'b0, cfg_ways};
    if (ways5 == 5'd0) begin
      ways5 = 5'd1;
    end
    if (ways5 > 5'(MAX_WAYS)) begin
      ways5 = 5'(MAX_WAYS);
    end
    ways_eff = WCNT_W'(ways5);
  end

  // Split the incoming address into set and tag
  logic [AW-1:0]    addr;
  logic [AW-1:0]    shifted;
  logic [AW-1:0]    set_mask;
  logic [SET_W-1:0] set_in;
  logic [AW-1:0]    tag_in;

  always_comb begin
    addr     = AW'(in_data.phys_addr);
    shifted  = addr >> cfg_bo;
    set_mask = ~({AW{1'b1}} << sbits);
    set_in   = SET_W'(shifted & set_mask);
    tag_in   = addr >> ({1'b0, cfg_bo} + {2'b00, sbits});
  end

  // Hold the accepted request
  logic [1:0]       req_q;
  logic [SET_W-1:0] set_q;
  logic [AW-1:0]    tag_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q <= in_data.req_type;
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Sweep address
  logic [SET_W-1:0] sweep_addr;
  logic             sweep_last;

  assign sweep_last = sweep_addr == SET_W'(MAX_SETS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_wr) begin
      sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
    end
  end

  // Set RAM: one row holds valid, tag and rank of every way
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic             is_access;
  logic             ram_we;

  assign is_access = (req_q == REQ_READ) || (req_q == REQ_WRITE);
  assign ram_we    = cmd.sweep_wr || (cmd.finish && is_access);

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.sweep_wr ? sweep_addr : set_q),
    .wdata (cmd.sweep_wr ? '0 : row_wr),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (row_rd)
  );

  // Tag compare, victim choice and rank update
  logic [MAX_WAYS-1:0] vld;
  logic [MAX_WAYS-1:0] en;
  logic [AW-1:0]       tg   [MAX_WAYS];
  logic [WAY_W-1:0]    rk   [MAX_WAYS];
  logic                hit;
  logic                free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    vic_way;
  logic [WAY_W-1:0]    best;
  logic [WAY_W-1:0]    way_sel;
  logic [WCNT_W-1:0]   old_rank;
  logic [WCNT_W-1:0]   rk_ext;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w] = row_rd[w*ENTRY_W + ENTRY_W - 1];
      tg[w]  = row_rd[w*ENTRY_W + WAY_W +: AW];
      rk[w]  = row_rd[w*ENTRY_W +: WAY_W];
      en[w]  = WCNT_W'(w) < ways_eff;
    end
    // Lowest matching way and lowest invalid way
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (en[w] && vld[w] && tg[w] == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (en[w] && !vld[w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    // Oldest way, lowest wins a tie
    vic_way = '0;
    best    = rk[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (en[w] && rk[w] > best) begin
        best    = rk[w];
        vic_way = WAY_W'(w);
      end
    end
    priority if (hit) begin
      way_sel  = hit_way;
      old_rank = WCNT_W'(rk[hit_way]);
    end else if (free) begin
      way_sel  = free_way;
      old_rank = ways_eff;
    end else begin
      way_sel  = vic_way;
      old_rank = WCNT_W'(rk[vic_way]);
    end
    // Age the ways that were younger than the touched one
    row_wr = row_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      rk_ext = WCNT_W'(rk[w]);
      if (WAY_W'(w) == way_sel) begin
        row_wr[w*ENTRY_W +: ENTRY_W] = {1'b1, tag_q, {WAY_W{1'b0}}};
      end else if (en[w] && vld[w] && rk_ext < old_rank && rk_ext + 1'b1 < ways_eff) begin
        row_wr[w*ENTRY_W +: WAY_W] = rk[w] + 1'b1;
      end
    end
  end

  // Counters
  logic [CNT_W-1:0] cnt_rd, cnt_rd_miss, cnt_wr, cnt_wr_miss;
  logic [CNT_W-1:0] cnt_rd_next, cnt_rd_miss_next, cnt_wr_next, cnt_wr_miss_next;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic inc);
    sat_inc = (inc && c != '1) ? c + 1'b1 : c;
  endfunction

  always_comb begin
    cnt_rd_next      = cnt_rd;
    cnt_rd_miss_next = cnt_rd_miss;
    cnt_wr_next      = cnt_wr;
    cnt_wr_miss_next = cnt_wr_miss;
    unique case (req_q)
      REQ_READ: begin
        cnt_rd_next      = sat_inc(cnt_rd, 1'b1);
        cnt_rd_miss_next = sat_inc(cnt_rd_miss, !hit);
      end
      REQ_WRITE: begin
        cnt_wr_next      = sat_inc(cnt_wr, 1'b1);
        cnt_wr_miss_next = sat_inc(cnt_wr_miss, !hit);
      end
      REQ_CLEAR: begin
        cnt_rd_next      = '0;
        cnt_rd_miss_next = '0;
        cnt_wr_next      = '0;
        cnt_wr_miss_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_rd      <= '0;
      cnt_rd_miss <= '0;
      cnt_wr      <= '0;
      cnt_wr_miss <= '0;
    end else if (cmd.finish) begin
      cnt_rd      <= cnt_rd_next;
      cnt_rd_miss <= cnt_rd_miss_next;
      cnt_wr      <= cnt_wr_next;
      cnt_wr_miss <= cnt_wr_miss_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.was_hit      <= is_access && hit;
      out_data.way_used     <= is_access ? 3'(way_sel) : 3'd0;
      out_data.set_used     <= is_access ? 10'(set_q) : 10'd0;
      out_data.read_total   <= cnt_rd_next;
      out_data.read_misses  <= cnt_rd_miss_next;
      out_data.write_total  <= cnt_wr_next;
      out_data.write_misses <= cnt_wr_miss_next;
    end
  end

  // Status to the controller
  assign sts.flush_req  = req_q == REQ_FLUSH;
  assign sts.sweep_last = sweep_last;
  assign sts.out_hold   = out_valid && out_stall;

endmodule

// ===== design/set_assoc_cache_lru_tags.sv =====
// Set-associative cache tag store with LRU replacement and access counters.
// A request is accepted with a set RAM read, then compared and written back once a held
// result has been taken; one transaction at a time, so the next request waits until this one finishes.
// Reset and every flush run a clearing sweep over all MAX_SETS rows (1024 by default) of
// the set RAM, one row per cycle, while input stalls; a flush shows its result first.
// Synchronous active-high reset; configuration resets to offset 6, 7 set bits, 2 ways.
module set_assoc_cache_lru_tags #(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sacl_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sacl_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [4:0]     cfg_data
);
  import sacl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tag store datapath
  sacl_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
